[rtl/qhcp_pkg.sv]
// Shared types and constants of the QUIC header connection ID parser.
// No dependencies; imported by every module.
`timescale 1ns / 1ps

package qhcp_pkg;

  // Result type codes
  localparam logic [1:0] RT_DEST_ID = 2'd0;
  localparam logic [1:0] RT_SRC_ID  = 2'd1;
  localparam logic [1:0] RT_STATUS  = 2'd2;

  // Verdict codes carried by a status result
  localparam logic [1:0] VERDICT_OK   = 2'd0;
  localparam logic [1:0] VERDICT_POLL = 2'd1;
  localparam logic [1:0] VERDICT_ERR  = 2'd2;

  // Reset value of the short header ID length register
  localparam logic [4:0] SHORT_CID_LEN_RST = 5'd8;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queue entry: the work one input beat leaves for the back end
  typedef struct packed {
    logic       has_id;
    logic [1:0] id_type;
    logic [7:0] id_byte;
    logic [4:0] id_index;
    logic       has_status;
    logic [1:0] verdict;
    logic [4:0] dest_len;
    logic [4:0] src_len;
  } qhcp_cmd_t;

endpackage

[rtl/qhcp_if.sv]
// Valid/ready channel interfaces for packet bytes in and parse results out.
// Does not import qhcp_pkg; its widths match the command fields there.
`timescale 1ns / 1ps

interface qhcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface qhcp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_type;
  logic [7:0] id_byte;
  logic [4:0] id_index;
  logic [1:0] verdict;
  logic [4:0] dest_id_len;
  logic [4:0] src_id_len;
  logic       run_last;

  modport source (output valid, output result_type, output id_byte, output id_index,
                  output verdict, output dest_id_len, output src_id_len,
                  output run_last, input ready);
  modport sink   (input valid, input result_type, input id_byte, input id_index,
                  input verdict, input dest_id_len, input src_id_len,
                  input run_last, output ready);
endinterface

[rtl/quic_header_cid_parser_unit.sv]
// Top level of the QUIC header connection ID parser.
// Uses qhcp_pkg, qhcp_if, qhcp_front, qhcp_queue and qhcp_back.
`timescale 1ns / 1ps

// The parser takes one packet byte per cycle and never stalls on its own:
// in_ch.ready drops only when the four-entry command queue is full. Each ID
// byte passes through the queue and the back end's output register as a result
// beat; the packet's last byte adds a status beat (ok, poll or error) carrying
// the destination and source ID lengths found. The single output register
// sends one result per cycle while out_ch.ready is high, so a last byte that
// also carries an ID byte gives an ID beat and a status beat, and the queue
// soaks that up. ID bytes are only trustworthy when the status that follows
// says ok. short_cid_len may be written only while no packet is in flight.
module quic_header_cid_parser_unit
  import qhcp_pkg::*;
#(
  parameter int MAX_CID_LEN = 20
) (
  input  logic        clk,
  input  logic        rst,
  qhcp_in_if.sink     in_ch,
  qhcp_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  qhcp_cmd_t q_wdata;
  qhcp_cmd_t q_head;

  qhcp_front #(
    .MAX_CID_LEN (MAX_CID_LEN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  qhcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  qhcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command queue overflow");

  // Commands only come from accepted beats
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (in_ch.valid && in_ch.ready))
    else $error("queue push without accepted input beat");

  // A status beat always closes its input beat's results
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.result_type == RT_STATUS) |-> out_ch.run_last)
    else $error("status beat without run_last");

  // ID bytes stay inside the largest ID
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.result_type != RT_STATUS)
      |-> (out_ch.id_index < 5'(MAX_CID_LEN)))
    else $error("ID byte index out of range");
`endif

endmodule

[rtl/qhcp_front.sv]
// Front end: accepts packet bytes, runs the header parse state machine and
// pushes one command per beat that produces results. Uses qhcp_pkg, qhcp_if.
`timescale 1ns / 1ps

module qhcp_front
  import qhcp_pkg::*;
#(
  parameter int MAX_CID_LEN = 20
) (
  input  logic          clk,
  input  logic          rst,
  qhcp_in_if.sink       in_ch,
  input  logic          cfg_wr_en,
  input  logic [4:0]    cfg_wr_data,
  input  logic          q_full,
  output logic          q_push,
  output qhcp_cmd_t     q_data
);

  typedef enum logic [7:0] {
    PH_FIRST = 8'b0000_0001,
    PH_SHORT = 8'b0000_0010,
    PH_HDR   = 8'b0000_0100,
    PH_DCID  = 8'b0000_1000,
    PH_SLEN  = 8'b0001_0000,
    PH_SCID  = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_POLL  = 8'b1000_0000
  } phase_t;

  // Byte 5 of a long header carries the destination ID length
  localparam logic [4:0] DLEN_POS = 5'd5;
  localparam logic [4:0] MAX_LEN  = 5'(MAX_CID_LEN);

  phase_t     phase, phase_next;
  logic [4:0] pos, pos_next;
  logic [4:0] dlen, dlen_next;
  logic [4:0] slen, slen_next;
  logic       err, err_next;
  logic [4:0] short_cid_len;

  logic       accept;
  logic [7:0] b;
  logic [5:0] pos_inc;
  logic [4:0] eff_len;
  logic       b_too_long;
  logic       has_id;
  logic [1:0] id_type;
  logic [1:0] verdict;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign pos_inc     = {1'b0, pos} + 6'd1;
  assign eff_len     = (short_cid_len > MAX_LEN) ? MAX_LEN : short_cid_len;
  assign b_too_long  = b > 8'(MAX_CID_LEN);

  // Next parse state for the current beat
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    dlen_next  = dlen;
    slen_next  = slen;
    err_next   = err;
    has_id     = 1'b0;
    id_type    = RT_DEST_ID;
    case (phase)
      PH_FIRST: begin
        if (b[7]) begin
          phase_next = PH_HDR;
          pos_next   = 5'd1;
        end else begin
          dlen_next  = eff_len;
          pos_next   = 5'd0;
          phase_next = (eff_len != 5'd0) ? PH_SHORT : PH_DONE;
        end
      end
      PH_SHORT: begin
        has_id   = 1'b1;
        pos_next = pos_inc[4:0];
        if (pos_inc >= {1'b0, dlen}) phase_next = PH_DONE;
      end
      PH_HDR: begin
        if (pos >= DLEN_POS) begin
          if (b_too_long) begin
            err_next   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            dlen_next  = b[4:0];
            pos_next   = 5'd0;
            phase_next = (b != 8'd0) ? PH_DCID : PH_SLEN;
          end
        end else begin
          pos_next = pos_inc[4:0];
        end
      end
      PH_DCID: begin
        has_id = 1'b1;
        if (pos_inc >= {1'b0, dlen}) begin
          pos_next   = 5'd0;
          phase_next = PH_SLEN;
        end else begin
          pos_next = pos_inc[4:0];
        end
      end
      PH_SLEN: begin
        if (b_too_long) begin
          phase_next = PH_POLL;
        end else begin
          slen_next  = b[4:0];
          pos_next   = 5'd0;
          phase_next = (b != 8'd0) ? PH_SCID : PH_DONE;
        end
      end
      PH_SCID: begin
        has_id   = 1'b1;
        id_type  = RT_SRC_ID;
        pos_next = pos_inc[4:0];
        if (pos_inc >= {1'b0, slen}) phase_next = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // Status verdict as the packet stands after this beat
  always_comb begin
    if (err_next)                 verdict = VERDICT_ERR;
    else if (phase_next == PH_POLL) verdict = VERDICT_POLL;
    else if (phase_next == PH_DONE) verdict = VERDICT_OK;
    else                          verdict = VERDICT_ERR;
  end

  // Command for the back end
  always_comb begin
    q_push            = accept && (has_id || in_ch.end_of_packet);
    q_data.has_id     = has_id;
    q_data.id_type    = id_type;
    q_data.id_byte    = b;
    q_data.id_index   = pos;
    q_data.has_status = in_ch.end_of_packet;
    q_data.verdict    = verdict;
    q_data.dest_len   = dlen_next;
    q_data.src_len    = slen_next;
  end

  // Parse state; cleared after every status
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      pos   <= 5'd0;
      dlen  <= 5'd0;
      slen  <= 5'd0;
      err   <= 1'b0;
    end else if (accept) begin
      if (in_ch.end_of_packet) begin
        phase <= PH_FIRST;
        pos   <= 5'd0;
        dlen  <= 5'd0;
        slen  <= 5'd0;
        err   <= 1'b0;
      end else begin
        phase <= phase_next;
        pos   <= pos_next;
        dlen  <= dlen_next;
        slen  <= slen_next;
        err   <= err_next;
      end
    end
  end

  // Short header ID length register
  always_ff @(posedge clk) begin
    if (rst) begin
      short_cid_len <= SHORT_CID_LEN_RST;
    end else if (cfg_wr_en) begin
      short_cid_len <= cfg_wr_data;
    end
  end

endmodule

[rtl/qhcp_queue.sv]
// Small command queue between front and back end, register based.
// Uses qhcp_pkg for the entry type and depth.
`timescale 1ns / 1ps

module qhcp_queue
  import qhcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qhcp_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output qhcp_cmd_t head
);

  localparam logic [Q_PTR_W-1:0] LAST_PTR = Q_PTR_W'(Q_DEPTH - 1);

  qhcp_cmd_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

[rtl/qhcp_back.sv]
// Back end: expands each queued command into one or two result beats
// through a single output register. Uses qhcp_pkg, qhcp_if.
`timescale 1ns / 1ps

module qhcp_back
  import qhcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  qhcp_cmd_t head,
  output logic      pop,
  qhcp_out_if.source out_ch
);

  logic out_valid;
  logic id_done;   // ID beat of the head already sent, status pending
  logic can_load;
  logic emit_id;

  assign out_ch.valid = out_valid;
  assign can_load     = !out_valid || out_ch.ready;
  assign emit_id      = head.has_id && !id_done;
  assign pop          = can_load && head_valid && (!emit_id || !head.has_status);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      id_done   <= 1'b0;
    end else if (can_load) begin
      out_valid <= head_valid;
      if (head_valid) id_done <= emit_id && head.has_status;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (can_load && head_valid) begin
      if (emit_id) begin
        out_ch.result_type <= head.id_type;
        out_ch.id_byte     <= head.id_byte;
        out_ch.id_index    <= head.id_index;
        out_ch.verdict     <= VERDICT_OK;
        out_ch.dest_id_len <= 5'd0;
        out_ch.src_id_len  <= 5'd0;
        out_ch.run_last    <= !head.has_status;
      end else begin
        out_ch.result_type <= RT_STATUS;
        out_ch.id_byte     <= 8'd0;
        out_ch.id_index    <= 5'd0;
        out_ch.verdict     <= head.verdict;
        out_ch.dest_id_len <= head.dest_len;
        out_ch.src_id_len  <= head.src_len;
        out_ch.run_last    <= 1'b1;
      end
    end
  end

endmodule
